### design/gpd_pkg.sv
// ----------------------------------------------------------------------------
// gpd_pkg
// Types, codes and small helper functions shared by the gamepad packet decoder.
// ----------------------------------------------------------------------------
package gpd_pkg;

   // Packet store and byte counter
   localparam int unsigned STORE_DEPTH = 18;
   localparam int unsigned COUNT_W     = 5;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

   // Length thresholds
   localparam logic [COUNT_W-1:0] LEN_MIN    = 5'd2;
   localparam logic [COUNT_W-1:0] LEN_MARK   = 5'd4;
   localparam logic [COUNT_W-1:0] LEN_STATUS = 5'd5;
   localparam logic [COUNT_W-1:0] LEN_STATE  = 5'd18;
   localparam logic [COUNT_W-1:0] LEN_INFO   = 5'd29;

   // Byte patterns
   localparam logic [7:0] BYTE_ZERO      = 8'h00;
   localparam logic [7:0] BYTE_BATT_TAG  = 8'h13;
   localparam logic [7:0] BYTE_MARKER    = 8'h09;
   localparam logic [7:0] BYTE_INFO_ID   = 8'h0f;
   localparam logic [7:0] BYTE_INFO_SUB  = 8'hf0;
   localparam logic [7:0] BYTE_STATE_ID  = 8'h01;
   localparam int unsigned BIT_LINK      = 3;   // byte 0: link status valid
   localparam int unsigned BIT_PAD       = 7;   // byte 1: controller present
   localparam int unsigned BIT_HEADSET   = 6;   // byte 1: headset present

   // State payload: bytes 6 to 17 of the packet
   localparam int unsigned PAYLOAD_FIRST = 6;
   localparam int unsigned PAYLOAD_LEN   = STORE_DEPTH - PAYLOAD_FIRST;

   // CSR map
   localparam int unsigned CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-1:0] CSR_ADDR_DEADZONE = 3'd0;
   localparam int unsigned DEADZONE_W = 15;

   typedef enum logic [1:0] {
      KIND_REJECT = 2'd0,
      KIND_STATUS = 2'd1,
      KIND_STATE  = 2'd2
   } event_kind_type;

   localparam logic [1:0] PRES_UNKNOWN = 2'd0;
   localparam logic [1:0] PRES_ABSENT  = 2'd1;
   localparam logic [1:0] PRES_PRESENT = 2'd2;

   localparam logic [1:0] BATT_NONE   = 2'd0;
   localparam logic [1:0] BATT_STATUS = 2'd1;
   localparam logic [1:0] BATT_INFO   = 2'd2;

   localparam logic [3:0] HAT_UP         = 4'd0;
   localparam logic [3:0] HAT_UP_RIGHT   = 4'd1;
   localparam logic [3:0] HAT_RIGHT      = 4'd2;
   localparam logic [3:0] HAT_DOWN_RIGHT = 4'd3;
   localparam logic [3:0] HAT_DOWN       = 4'd4;
   localparam logic [3:0] HAT_DOWN_LEFT  = 4'd5;
   localparam logic [3:0] HAT_LEFT       = 4'd6;
   localparam logic [3:0] HAT_UP_LEFT    = 4'd7;
   localparam logic [3:0] HAT_CENTRE     = 4'd8;

   // Classified packet, front to back
   typedef struct packed {
      event_kind_type                  kind;
      logic [1:0]                      conn;
      logic [1:0]                      head;
      logic [1:0]                      src;
      logic [7:0]                      raw;
      logic                            mark;
      logic [PAYLOAD_LEN-1:0][7:0]     payload;
   } pkt_rec_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

   // Decoded event, back to top
   typedef struct packed {
      event_kind_type kind;
      logic [1:0]     conn;
      logic [1:0]     head;
      logic [1:0]     src;
      logic [7:0]     raw;
      logic           mark;
      logic [14:0]    buttons;
      logic [3:0]     hat;
      logic [15:0]    trig;
      logic [31:0]    lstick;
      logic [31:0]    rstick;
   } rsp_item_type;

   // d-pad bits: 0 up, 1 down, 2 left, 3 right; opposing pairs cancel
   function automatic logic [3:0] hat_from_dpad(input logic [3:0] dpad);
      logic up, down, left, right;
      logic [3:0] hat;
      up    = dpad[0] & ~dpad[1];
      down  = dpad[1] & ~dpad[0];
      left  = dpad[2] & ~dpad[3];
      right = dpad[3] & ~dpad[2];
      if      (up   & ~left & ~right) hat = HAT_UP;
      else if (up   &  right)         hat = HAT_UP_RIGHT;
      else if (right & ~up & ~down)   hat = HAT_RIGHT;
      else if (down &  right)         hat = HAT_DOWN_RIGHT;
      else if (down & ~left & ~right) hat = HAT_DOWN;
      else if (down &  left)          hat = HAT_DOWN_LEFT;
      else if (left & ~up & ~down)    hat = HAT_LEFT;
      else if (up   &  left)          hat = HAT_UP_LEFT;
      else                            hat = HAT_CENTRE;
      return hat;
   endfunction

   // Zero an axis whose magnitude is under the threshold (0 disables).
   // -32768 gives magnitude 0x8000, above any threshold.
   function automatic logic [15:0] deadzone_axis(input logic [15:0] v,
                                                 input logic [DEADZONE_W-1:0] thr);
      logic [15:0] mag;
      logic [15:0] res;
      mag = v[15] ? (16'd0 - v) : v;
      res = v;
      if ((thr != '0) && ({1'b0, thr} > mag)) res = '0;
      return res;
   endfunction

endpackage

### design/gpd_front.sv
// ----------------------------------------------------------------------------
// gpd_front
// Byte counter, packet store and header classification.
// ----------------------------------------------------------------------------
module gpd_front import gpd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        byte_accept,
   input  logic [7:0]  packet_byte,
   input  logic        end_of_packet,
   output logic        push,
   output pkt_rec_type rec
);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [7:0]         store_ff [STORE_DEPTH];
   logic [STORE_DEPTH-1:0][7:0] d;
   logic [COUNT_W-1:0] len;

   // Current packet as seen with the incoming byte merged in
   always_comb begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
         d[i] = (count_ff == COUNT_W'(i)) ? packet_byte : store_ff[i];
      end
      len = (count_ff == COUNT_MAX) ? COUNT_MAX : count_ff + 5'd1;
   end

   always_comb begin
      count_in = count_ff;
      if (byte_accept) begin
         count_in = end_of_packet ? '0 : len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (byte_accept && (count_ff < COUNT_W'(STORE_DEPTH))) begin
         store_ff[count_ff] <= packet_byte;
      end
   end

   // Header classification
   always_comb begin
      rec.kind    = KIND_STATUS;
      rec.conn    = PRES_UNKNOWN;
      rec.head    = PRES_UNKNOWN;
      rec.src     = BATT_NONE;
      rec.raw     = '0;
      rec.mark    = 1'b0;
      for (int i = 0; i < PAYLOAD_LEN; i++) begin
         rec.payload[i] = d[PAYLOAD_FIRST + i];
      end

      if (len < LEN_MIN) begin
         rec.kind = KIND_REJECT;
      end else begin
         if ((len >= LEN_STATUS) && (d[0] == BYTE_ZERO) && (d[1] == BYTE_ZERO) &&
             (d[2] == BYTE_ZERO) && (d[3] == BYTE_BATT_TAG)) begin
            rec.src = BATT_STATUS;
            rec.raw = d[4];
         end
         if ((d[1] == BYTE_MARKER) || ((len >= LEN_MARK) && (d[3] == BYTE_MARKER))) begin
            rec.mark = 1'b1;
         end
         if (d[0][BIT_LINK]) begin
            rec.conn = d[1][BIT_PAD]     ? PRES_PRESENT : PRES_ABSENT;
            rec.head = d[1][BIT_HEADSET] ? PRES_PRESENT : PRES_ABSENT;
         end
         if ((len >= LEN_INFO) && (d[0] == BYTE_ZERO) && (d[1] == BYTE_INFO_ID) &&
             (d[2] == BYTE_ZERO) && (d[3] == BYTE_INFO_SUB) &&
             (d[16] == BYTE_BATT_TAG)) begin
            rec.src = BATT_INFO;
            rec.raw = d[17];
         end
         if (d[1] == BYTE_STATE_ID) begin
            if (len < LEN_STATE) begin
               rec.kind = KIND_REJECT;
            end else if (d[4] == BYTE_ZERO) begin
               rec.kind = KIND_STATE;
               if (rec.conn == PRES_UNKNOWN) rec.conn = PRES_PRESENT;
            end
         end
      end

      if (rec.kind == KIND_REJECT) begin
         rec.conn = PRES_UNKNOWN;
         rec.head = PRES_UNKNOWN;
         rec.src  = BATT_NONE;
         rec.raw  = '0;
         rec.mark = 1'b0;
      end
   end

   assign push = byte_accept & end_of_packet;

endmodule

### design/gpd_queue.sv
// ----------------------------------------------------------------------------
// gpd_queue
// Short FIFO of classified packets between front and back.
// ----------------------------------------------------------------------------
module gpd_queue import gpd_pkg::*; #(
   parameter int unsigned DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  pkt_rec_type      push_rec,
   input  logic             pop,
   output pkt_rec_type      head_rec,
   output queue_status_type status
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   pkt_rec_type        mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign status.full      = (count_ff == CNT_W'(DEPTH));
   assign status.not_empty = (count_ff != '0);
   assign do_push = push & ~status.full;
   assign do_pop  = pop & status.not_empty;
   assign head_rec = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule

### design/gpd_back.sv
// ----------------------------------------------------------------------------
// gpd_back
// Controller state decode, deadzone and result register.
// ----------------------------------------------------------------------------
module gpd_back import gpd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  pkt_rec_type           head_rec,
   input  logic                  head_valid,
   input  logic [DEADZONE_W-1:0] deadzone,
   input  logic                  rsp_ready,
   output logic                  pop,
   output logic                  rsp_valid,
   output rsp_item_type          rsp_item
);

   logic         valid_ff, valid_in;
   rsp_item_type item_ff, item_in;
   logic [7:0]   btn_lo, btn_hi;

   assign pop = head_valid & (~valid_ff | rsp_ready);

   always_comb begin
      btn_lo = head_rec.payload[0];   // byte 6
      btn_hi = head_rec.payload[1];   // byte 7

      item_in.kind    = head_rec.kind;
      item_in.conn    = head_rec.conn;
      item_in.head    = head_rec.head;
      item_in.src     = head_rec.src;
      item_in.raw     = head_rec.raw;
      item_in.mark    = head_rec.mark;
      item_in.buttons = '0;
      item_in.hat     = HAT_CENTRE;
      item_in.trig    = '0;
      item_in.lstick  = '0;
      item_in.rstick  = '0;
      if (head_rec.kind == KIND_STATE) begin
         item_in.buttons = {btn_hi[7:4], btn_hi[2:0], btn_lo};
         item_in.hat     = hat_from_dpad(btn_lo[3:0]);
         item_in.trig    = {head_rec.payload[3], head_rec.payload[2]};
         item_in.lstick  = {deadzone_axis({head_rec.payload[7],  head_rec.payload[6]},
                                          deadzone),
                            deadzone_axis({head_rec.payload[5],  head_rec.payload[4]},
                                          deadzone)};
         item_in.rstick  = {deadzone_axis({head_rec.payload[11], head_rec.payload[10]},
                                          deadzone),
                            deadzone_axis({head_rec.payload[9],  head_rec.payload[8]},
                                          deadzone)};
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (pop) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         item_ff <= item_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule

### design/gamepad_receiver_packet_decoder_top.sv
// ----------------------------------------------------------------------------
// gamepad_receiver_packet_decoder_top
// Decodes wireless gamepad receiver packets, fed a byte per transaction,
// into one event per packet.
// ----------------------------------------------------------------------------
//
//  Channel | Ports   | Direction | Moves
//  --------+---------+-----------+-------------------------------------------
//  req     | req_t*  | in        | one packet byte, tlast on the final byte
//  rsp     | rsp_t*  | out       | one decoded event per packet
//  csr     | csr_p*  | in/out    | APB-style access to the deadzone threshold
//
//  One byte is taken every cycle unless the queue is full. The front stage
//  counts and stores bytes and classifies the header in the cycle the last
//  byte arrives; the queue then feeds the back's result register (rsp_tvalid).
//  The front/back queue (QUEUE_DEPTH packets) absorbs rsp stalls; req_tready
//  drops only when it is full. Non-final bytes still need a free slot.
//  Synchronous reset clears the byte count, queue and output valid; the
//  deadzone threshold resets to zero (disabled).
//
module gamepad_receiver_packet_decoder_top import gpd_pkg::*; #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   // Packet bytes
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] packet_byte
   input  logic                  req_tlast,   // end_of_packet
   // Decoded events
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [119:0]          rsp_tdata,   // [1:0] connected_code, [3:2] headset_code,
                                              // [5:4] battery_source, [13:6] battery_raw,
                                              // [14] battery_marker, [29:15] button_bits,
                                              // [33:30] hat_direction, [49:34] trigger_pair,
                                              // [81:50] left_stick, [113:82] right_stick,
                                              // [119:114] zero
   output logic [1:0]            rsp_tuser,   // [1:0] event_kind
   // Configuration
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic [DEADZONE_W-1:0] deadzone_ff, deadzone_in;
   logic                  csr_write;

   logic                  byte_accept;
   logic                  push;
   pkt_rec_type           push_rec;
   pkt_rec_type           head_rec;
   queue_status_type      q_status;
   logic                  pop;
   rsp_item_type          rsp_item;

   // ---------------- CSR ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready &
                       (csr_paddr == CSR_ADDR_DEADZONE);

   always_comb begin
      deadzone_in = deadzone_ff;
      if (csr_write) deadzone_in = csr_pwdata[DEADZONE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         deadzone_ff <= '0;
      end else begin
         deadzone_ff <= deadzone_in;
      end
   end

   // Unmapped addresses read as zero
   assign csr_prdata = (csr_paddr == CSR_ADDR_DEADZONE) ?
                       {{(32 - DEADZONE_W){1'b0}}, deadzone_ff} : 32'd0;

   // ---------------- Front ----------------
   assign req_tready  = ~q_status.full;
   assign byte_accept = req_tvalid & req_tready;

   gpd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .byte_accept   (byte_accept),
      .packet_byte   (req_tdata),
      .end_of_packet (req_tlast),
      .push          (push),
      .rec           (push_rec)
   );

   // ---------------- Queue ----------------
   gpd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .pop      (pop),
      .head_rec (head_rec),
      .status   (q_status)
   );

   // ---------------- Back ----------------
   gpd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_rec   (head_rec),
      .head_valid (q_status.not_empty),
      .deadzone   (deadzone_ff),
      .rsp_ready  (rsp_tready),
      .pop        (pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_item   (rsp_item)
   );

   assign rsp_tuser = rsp_item.kind;
   assign rsp_tdata = {6'd0,
                       rsp_item.rstick,
                       rsp_item.lstick,
                       rsp_item.trig,
                       rsp_item.hat,
                       rsp_item.buttons,
                       rsp_item.mark,
                       rsp_item.raw,
                       rsp_item.src,
                       rsp_item.head,
                       rsp_item.conn};

endmodule

### design/gpd_checker.sv
// ----------------------------------------------------------------------------
// gpd_checker
// Port-level checks on the decoder's result channel.
// ----------------------------------------------------------------------------
module gpd_checker import gpd_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [119:0] rsp_tdata,
   input logic [1:0]   rsp_tuser
);

   // A stalled event stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp event dropped or changed while stalled");

   // Nothing comes out straight after reset
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // Rejected packet: all fields clear, hat centred
   a_reject_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_REJECT) |->
         (rsp_tdata[29:0] == 30'd0) && (rsp_tdata[33:30] == HAT_CENTRE) &&
         (rsp_tdata[119:34] == 86'd0))
      else $error("rejected event carries data");

   // Event without state: no controls reported
   a_status_no_state: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_STATUS) |->
         (rsp_tdata[29:15] == 15'd0) && (rsp_tdata[33:30] == HAT_CENTRE) &&
         (rsp_tdata[119:34] == 86'd0))
      else $error("status-only event carries controller state");

   // State event never reports controller presence as unknown
   a_state_present: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_STATE) |-> (rsp_tdata[1:0] != PRES_UNKNOWN))
      else $error("state event with unknown presence");

endmodule

bind gamepad_receiver_packet_decoder_top gpd_checker u_gpd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

### dv/tb_gamepad_receiver_packet_decoder_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gamepad_receiver_packet_decoder_top
// Self-checking bench for the gamepad receiver packet decoder: packets are
// streamed a byte per transaction, each decoded event is predicted as its
// last byte is taken and compared field by field with what the block sends.
// ----------------------------------------------------------------------------
module tb_gamepad_receiver_packet_decoder_top;
   import gpd_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 300000;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned PHASE_BYTES   = 335;   // at least this many random bytes per threshold setting

   // Byte patterns the decoder looks for
   localparam logic [7:0] PAT_BATT_TAG = 8'h13;
   localparam logic [7:0] PAT_MARKER   = 8'h09;
   localparam logic [7:0] PAT_INFO_ID  = 8'h0f;
   localparam logic [7:0] PAT_INFO_SUB = 8'hf0;
   localparam logic [7:0] PAT_STATE_ID = 8'h01;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } packet_byte_type;

   typedef struct packed {
      event_kind_type kind;
      logic [1:0]     conn;
      logic [1:0]     head;
      logic [1:0]     src;
      logic [7:0]     raw;
      logic           mark;
      logic [14:0]    buttons;
      logic [3:0]     hat;
      logic [15:0]    trig;
      logic [31:0]    lstick;
      logic [31:0]    rstick;
   } decoded_event_type;

   typedef enum logic [1:0] {
      RX_OPEN,      // always ready
      RX_COIN,      // ready half the time
      RX_SPARSE,    // ready a quarter of the time
      RX_PERIODIC   // long regular stalls
   } rx_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata   = 8'd0;   // [7:0] packet_byte
   logic                  req_tlast   = 1'b0;   // end_of_packet
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [119:0]          rsp_tdata;            // conn, head, src, raw, mark, buttons,
                                                // hat, trig, lstick, rstick, zero pad
   logic [1:0]            rsp_tuser;            // [1:0] event_kind
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [31:0]           csr_pwdata  = 32'd0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   // Predictor state: its own byte count, packet store and threshold copy
   int unsigned    model_count = 0;
   logic [7:0]     model_store [0:17] = '{default: 8'd0};
   logic [14:0]    dz_threshold = 15'd0;

   packet_byte_type   byte_backlog [$];    // bytes waiting for the driver
   decoded_event_type awaited_events [$];  // predicted events not yet seen
   int unsigned    fault_count = 0;
   int unsigned    cycle_count;

   // Scratch packet built by the stimulus before it is queued
   logic [7:0]     pkt_buf [0:47];
   int unsigned    pkt_len;

   // Sender and receiver pacing
   int unsigned    burst_left = 0;
   int unsigned    gap_left   = 0;
   rx_mode_type    rx_mode    = RX_OPEN;
   int unsigned    mode_left  = 0;
   logic [3:0]     stall_tick = 4'd0;

   gamepad_receiver_packet_decoder_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   // d-pad bits: 0 up, 1 down, 2 left, 3 right; x grows right, y grows down
   function automatic logic [3:0] hat_of_dpad(input logic [3:0] dpad);
      int x, y;
      x = int'(dpad[3]) - int'(dpad[2]);
      y = int'(dpad[1]) - int'(dpad[0]);
      if (x == 0 && y < 0) return HAT_UP;
      if (x > 0  && y < 0) return HAT_UP_RIGHT;
      if (x > 0  && y == 0) return HAT_RIGHT;
      if (x > 0  && y > 0) return HAT_DOWN_RIGHT;
      if (x == 0 && y > 0) return HAT_DOWN;
      if (x < 0  && y > 0) return HAT_DOWN_LEFT;
      if (x < 0  && y == 0) return HAT_LEFT;
      if (x < 0  && y < 0) return HAT_UP_LEFT;
      return HAT_CENTRE;
   endfunction

   // magnitude on 17 bits so that -32768 reads as 32768 and always survives
   function automatic logic [15:0] zero_small_axis(input logic [15:0] axis);
      logic [16:0] mag;
      mag = axis[15] ? (17'h10000 - {1'b0, axis}) : {1'b0, axis};
      if (dz_threshold != 15'd0 && mag < {2'b00, dz_threshold}) return 16'd0;
      return axis;
   endfunction

   function automatic decoded_event_type decode_packet(input int unsigned len);
      decoded_event_type ev;
      ev      = '0;
      ev.kind = KIND_STATUS;
      ev.hat  = HAT_CENTRE;
      if (len < 2) begin
         ev.kind = KIND_REJECT;
      end else begin
         if (len >= 5 && model_store[0] == 8'd0 && model_store[1] == 8'd0 &&
             model_store[2] == 8'd0 && model_store[3] == PAT_BATT_TAG) begin
            ev.src = BATT_STATUS;
            ev.raw = model_store[4];
         end
         if (model_store[1] == PAT_MARKER || (len >= 4 && model_store[3] == PAT_MARKER))
            ev.mark = 1'b1;
         if (model_store[0][3]) begin
            ev.conn = model_store[1][7] ? PRES_PRESENT : PRES_ABSENT;
            ev.head = model_store[1][6] ? PRES_PRESENT : PRES_ABSENT;
         end
         if (len >= 29 && model_store[0] == 8'd0 && model_store[1] == PAT_INFO_ID &&
             model_store[2] == 8'd0 && model_store[3] == PAT_INFO_SUB &&
             model_store[16] == PAT_BATT_TAG) begin
            ev.src = BATT_INFO;
            ev.raw = model_store[17];
         end
         if (model_store[1] == PAT_STATE_ID) begin
            if (len < 18) begin
               ev.kind = KIND_REJECT;
            end else if (model_store[4] == 8'd0) begin
               ev.kind    = KIND_STATE;
               ev.buttons = {model_store[7][7:4], model_store[7][2:0], model_store[6]};
               ev.hat     = hat_of_dpad(model_store[6][3:0]);
               ev.trig    = {model_store[9], model_store[8]};
               ev.lstick  = {zero_small_axis({model_store[13], model_store[12]}),
                             zero_small_axis({model_store[11], model_store[10]})};
               ev.rstick  = {zero_small_axis({model_store[17], model_store[16]}),
                             zero_small_axis({model_store[15], model_store[14]})};
               if (ev.conn == PRES_UNKNOWN) ev.conn = PRES_PRESENT;
            end
         end
      end
      if (ev.kind == KIND_REJECT) begin
         ev     = '0;
         ev.hat = HAT_CENTRE;
      end
      return ev;
   endfunction

   // One accepted byte: store, count (saturating), and predict on tlast
   task automatic absorb_byte(input logic [7:0] data, input logic last);
      if (model_count < 18) model_store[model_count] = data;
      if (model_count < 31) model_count++;
      if (last) begin
         awaited_events.push_back(decode_packet(model_count));
         model_count = 0;
      end
   endtask

   // ------------------------------------------------------------------------
   // Driver: bursts of random length with random gaps between them
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : byte_driver
      packet_byte_type next_byte;
      if (reset) begin
         req_tvalid  <= 1'b0;
         req_tdata   <= 8'd0;
         req_tlast   <= 1'b0;
         burst_left  = 0;
         gap_left    = 0;
         model_count = 0;
      end else begin
         if (req_tvalid && req_tready) absorb_byte(req_tdata, req_tlast);
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (byte_backlog.size() > 0) begin
               next_byte = byte_backlog.pop_front();
               req_tdata  <= next_byte.data;
               req_tlast  <= next_byte.last;
               req_tvalid <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  // now and then a long unbroken stream
                  burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                           : $urandom_range(0, 16);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver back-pressure: a mode held for a while, then another
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            rx_mode   = rx_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(40, 160);
         end else begin
            mode_left--;
         end
         stall_tick = stall_tick + 4'd1;
         case (rx_mode)
            RX_OPEN:   rsp_tready <= 1'b1;
            RX_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
            default:   rsp_tready <= (stall_tick < 4'd4);
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: each event transaction against the oldest prediction
   // ------------------------------------------------------------------------
   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] seen);
      if (want !== seen) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, seen);
         fault_count++;
      end
   endfunction

   always @(posedge clock) begin : event_monitor
      decoded_event_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_events.size() == 0) begin
            $display("%0t: event with nothing predicted, actual kind 0x%0h data 0x%0h",
                     $time, rsp_tuser, rsp_tdata);
            fault_count++;
         end else begin
            want = awaited_events.pop_front();
            check_field("event_kind",     want.kind,    rsp_tuser);
            check_field("connected_code", want.conn,    rsp_tdata[1:0]);
            check_field("headset_code",   want.head,    rsp_tdata[3:2]);
            check_field("battery_source", want.src,     rsp_tdata[5:4]);
            check_field("battery_raw",    want.raw,     rsp_tdata[13:6]);
            check_field("battery_marker", want.mark,    rsp_tdata[14]);
            check_field("button_bits",    want.buttons, rsp_tdata[29:15]);
            check_field("hat_direction",  want.hat,     rsp_tdata[33:30]);
            check_field("trigger_pair",   want.trig,    rsp_tdata[49:34]);
            check_field("left_stick",     want.lstick,  rsp_tdata[81:50]);
            check_field("right_stick",    want.rstick,  rsp_tdata[113:82]);
            check_field("tdata_pad",      32'd0,        rsp_tdata[119:114]);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   // Register write (setup then access), then read it straight back
   task automatic program_deadzone(input logic [14:0] value);
      logic [31:0] readback;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_DEADZONE;
      csr_pwdata  <= {17'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      dz_threshold = value;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      readback = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      check_field("deadzone readback", {17'd0, value}, readback);
   endtask

   task automatic start_packet(input int unsigned len, input logic [7:0] fill);
      pkt_len = len;
      for (int i = 0; i < 48; i++) pkt_buf[i] = fill;
   endtask

   task automatic queue_packet();
      for (int unsigned i = 0; i < pkt_len; i++)
         byte_backlog.push_back('{data: pkt_buf[i], last: (i == pkt_len - 1)});
   endtask

   // Wait until every byte is in and every event is out, then let it settle
   task automatic drain();
      do @(posedge clock);
      while (byte_backlog.size() != 0 || req_tvalid || awaited_events.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Stick values: random, near zero, at the extremes or around the current threshold
   function automatic logic [15:0] pick_axis();
      logic [15:0] thr;
      thr = {1'b0, dz_threshold};
      case ($urandom_range(0, 7))
         0: return 16'($urandom);
         1: return 16'($urandom_range(0, 511)) - 16'd256;
         2: return 16'h8000;
         3: return 16'h7fff;
         4: return thr;
         5: return thr - 16'd1;
         6: return 16'd0 - thr;
         default: return 16'd0 - (thr - 16'd1);
      endcase
   endfunction

   task automatic build_random_packet();
      int unsigned pick;
      logic [15:0] axis;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         // controller state, mostly exactly 18 bytes
         pkt_len = ($urandom_range(0, 3) == 0) ? $urandom_range(19, 40) : 18;
         for (int i = 0; i < 48; i++) pkt_buf[i] = 8'($urandom);
         pkt_buf[1] = PAT_STATE_ID;
         pkt_buf[4] = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'd0;
         for (int i = 0; i < 4; i++) begin
            axis = pick_axis();
            pkt_buf[10 + 2*i] = axis[7:0];
            pkt_buf[11 + 2*i] = axis[15:8];
         end
      end else if (pick < 60) begin
         // status with battery level
         start_packet($urandom_range(5, 8), 8'($urandom));
         for (int i = 0; i < 3; i++) pkt_buf[i] = 8'd0;
         pkt_buf[3] = PAT_BATT_TAG;
         pkt_buf[4] = 8'($urandom);
      end else if (pick < 70) begin
         // initial info, sometimes with a broken pattern byte or cut short
         pkt_len = $urandom_range(29, 36);
         for (int i = 0; i < 48; i++) pkt_buf[i] = 8'($urandom);
         pkt_buf[0]  = 8'd0;
         pkt_buf[1]  = PAT_INFO_ID;
         pkt_buf[2]  = 8'd0;
         pkt_buf[3]  = PAT_INFO_SUB;
         pkt_buf[16] = PAT_BATT_TAG;
         if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 4))
               0: pkt_buf[0]  = 8'($urandom_range(1, 255));
               1: pkt_buf[1]  = PAT_STATE_ID;
               2: pkt_buf[2]  = 8'($urandom_range(1, 255));
               3: pkt_buf[16] = 8'($urandom);
               default: pkt_len = $urandom_range(18, 28);
            endcase
         end
      end else if (pick < 80) begin
         // link status
         pkt_len = $urandom_range(2, 6);
         for (int i = 0; i < 48; i++) pkt_buf[i] = 8'($urandom);
         pkt_buf[0][3] = 1'b1;
         case ($urandom_range(0, 4))
            0: pkt_buf[1] = PAT_MARKER;
            1: pkt_buf[1] = 8'hc0;
            2: pkt_buf[1] = 8'h80;
            3: pkt_buf[1] = 8'h40;
            default: ;
         endcase
         if ($urandom_range(0, 3) == 0) pkt_buf[3] = PAT_MARKER;
      end else if (pick < 90) begin
         // too short, or a state packet cut off early
         pkt_len = ($urandom_range(0, 2) == 0) ? 1 : $urandom_range(2, 17);
         for (int i = 0; i < 48; i++) pkt_buf[i] = 8'($urandom);
         pkt_buf[1] = PAT_STATE_ID;
      end else begin
         pkt_len = $urandom_range(1, 40);
         for (int i = 0; i < 48; i++) pkt_buf[i] = 8'($urandom);
      end
   endtask

   task automatic random_phase(input int unsigned byte_budget);
      int unsigned queued;
      queued = 0;
      while (queued < byte_budget) begin
         build_random_packet();
         queue_packet();
         queued += pkt_len;
      end
      drain();
   endtask

   // ------------------------------------------------------------------------
   // Run-time guard
   // ------------------------------------------------------------------------
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // widest deadzone for the directed packets
      program_deadzone(15'h7fff);

      // a lone flagged byte is too short
      start_packet(1, 8'hff);
      queue_packet();
      // link byte: pad and headset present
      start_packet(2, 8'h00);
      pkt_buf[0] = 8'h08;
      pkt_buf[1] = 8'hc0;
      queue_packet();
      // link byte: both absent, marker in byte 1
      start_packet(2, 8'h00);
      pkt_buf[0] = 8'hf8;
      pkt_buf[1] = PAT_MARKER;
      queue_packet();
      // marker in byte 3
      start_packet(4, 8'h00);
      pkt_buf[3] = PAT_MARKER;
      queue_packet();
      // byte 3 left over from the last packet must not count at length 3
      start_packet(3, 8'h00);
      queue_packet();
      // battery level from a status packet
      start_packet(5, 8'h00);
      pkt_buf[3] = PAT_BATT_TAG;
      pkt_buf[4] = 8'hab;
      queue_packet();
      // same header one byte short: no battery
      start_packet(4, 8'h00);
      pkt_buf[3] = PAT_BATT_TAG;
      queue_packet();
      // state packets cut short are rejected
      start_packet(2, 8'h00);
      pkt_buf[1] = PAT_STATE_ID;
      queue_packet();
      start_packet(17, 8'h5a);
      pkt_buf[1] = PAT_STATE_ID;
      queue_packet();
      // unknown payload type: event without state
      start_packet(18, 8'h00);
      pkt_buf[0] = 8'h08;
      pkt_buf[1] = PAT_STATE_ID;
      pkt_buf[4] = 8'h80;
      queue_packet();
      // state, presence implied, up with down cancels, sticks at the edges
      start_packet(18, 8'h00);
      pkt_buf[1]  = PAT_STATE_ID;
      pkt_buf[6]  = 8'hf3;
      pkt_buf[7]  = 8'hff;
      pkt_buf[8]  = 8'hff;
      pkt_buf[11] = 8'h80;   // x = -32768, never zeroed
      pkt_buf[12] = 8'hff;
      pkt_buf[13] = 8'h7f;   // y = 32767, equal to the threshold
      pkt_buf[14] = 8'hfe;
      pkt_buf[15] = 8'h7f;   // x = 32766, zeroed
      pkt_buf[16] = 8'h01;
      pkt_buf[17] = 8'h80;   // y = -32767, equal to the threshold
      queue_packet();
      // state with link bit set, left with right cancels, axes of -1
      start_packet(18, 8'hff);
      pkt_buf[0] = 8'h08;
      pkt_buf[1] = PAT_STATE_ID;
      pkt_buf[4] = 8'h00;
      pkt_buf[6] = 8'h0c;
      queue_packet();
      // diagonals
      start_packet(18, 8'h00);
      pkt_buf[1] = PAT_STATE_ID;
      pkt_buf[6] = 8'h09;
      queue_packet();
      start_packet(18, 8'h00);
      pkt_buf[1] = PAT_STATE_ID;
      pkt_buf[6] = 8'h06;
      pkt_buf[9] = 8'hff;
      queue_packet();
      // initial info with battery, shortest length
      start_packet(29, 8'h3c);
      pkt_buf[0]  = 8'h00;
      pkt_buf[1]  = PAT_INFO_ID;
      pkt_buf[2]  = 8'h00;
      pkt_buf[3]  = PAT_INFO_SUB;
      pkt_buf[16] = PAT_BATT_TAG;
      pkt_buf[17] = 8'hc5;
      queue_packet();
      // one byte short of that: no battery
      pkt_len = 28;
      queue_packet();
      // long info packet, count saturates
      pkt_len = 45;
      pkt_buf[17] = 8'h00;
      queue_packet();
      // long state packet, bytes past the store only counted
      start_packet(40, 8'h00);
      pkt_buf[1] = PAT_STATE_ID;
      pkt_buf[6] = 8'h0a;
      pkt_buf[7] = 8'h88;
      queue_packet();
      // all ones
      start_packet(18, 8'hff);
      queue_packet();
      drain();

      // random traffic under several thresholds, extremes included
      program_deadzone(15'd0);
      random_phase(PHASE_BYTES);
      program_deadzone(15'd1);
      random_phase(PHASE_BYTES);
      program_deadzone(15'($urandom_range(2, 32766)));
      random_phase(PHASE_BYTES);
      program_deadzone(15'h7fff);
      random_phase(PHASE_BYTES);

      if (fault_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

### gamepad_receiver_packet_decoder_top.f
design/gpd_pkg.sv
design/gpd_front.sv
design/gpd_queue.sv
design/gpd_back.sv
design/gamepad_receiver_packet_decoder_top.sv
design/gpd_checker.sv
dv/tb_gamepad_receiver_packet_decoder_top.sv
